// ===== src/dfb_pkg.sv =====
// Shared types, constants and the exponential ROM for the depth fog blend core.
`timescale 1ns / 1ps

package dfb_pkg;

  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int EXP_IDX_W         = $clog2(EXP_TABLE_ENTRIES);
  localparam int ROM_ADDR_W        = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int POS_W             = 16 + EXP_IDX_W;

  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [31:0] LOG2E_Q31 = 32'd3098164010;
  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [21:0] EXP_SAT   = 22'h200000;
  localparam logic [15:0] ROUND_HALF = 16'h8000;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_STAGES  = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOG_ENABLE  = 3'd0,
    REG_FOG_MODE    = 3'd1,
    REG_FOG_END     = 3'd2,
    REG_FOG_SCALE   = 3'd3,
    REG_FOG_DENSITY = 3'd4,
    REG_FOG_RGB     = 3'd5
  } cfg_reg_t;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam int         MODE_SQ_BIT = 1;

  typedef logic [16:0] exp_rom_t [EXP_TABLE_ENTRIES+1];

  // 2^-(i/N) as exp(-t), Taylor series in Q1.32, rounded to Q1.16
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] t;
    logic [63:0] acc;
    logic [63:0] term;
    for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
      t    = (64'(i) * LN2_Q32) / EXP_TABLE_ENTRIES;
      acc  = 64'h1_0000_0000;
      term = 64'h1_0000_0000;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * t) >> 32) / 64'(n);
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      rom[i] = 17'((acc + 64'd32768) >> 16);
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  typedef struct packed {
    logic [2:0][15:0] col;
    logic [30:0]      d;
    logic [31:0]      diff;
    logic             lin_pos;
    logic [63:0]      lin_prod;
    logic [62:0]      exp_prod;
    logic [16:0]      lin_f;
    logic [21:0]      x;
    logic [43:0]      sq;
    logic [21:0]      e;
    logic [53:0]      y;
    logic [16:0]      a;
    logic [16:0]      dab;
    logic [15:0]      r;
    logic [4:0]       k;
    logic             kill;
    logic [32:0]      ip;
    logic [16:0]      f;
    logic [2:0][32:0] pc;
    logic [2:0][32:0] pf;
  } pipe_t;

endpackage

// ===== src/depth_fog_blend_core.sv =====
// Top level of the depth fog blend core: eleven-stage fog coefficient and blend pipeline.
`timescale 1ns / 1ps

// channel  dir  fields (low bit first)
// s_*      in   tdata: depth[31:0] red_in[47:32] green_in[63:48] blue_in[79:64]
// m_*      out  tdata: red_out[15:0] green_out[31:16] blue_out[47:32]
// cfg_*    in   cfg_index selects register, cfg_wdata LSB-aligned
//
// One request accepted per cycle unless the pipe is full and m_tready is low.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up.
// Reset clears the stage valid bits and fog registers, not data registers. Stages read the
// fog registers live: the user must change them only with the pipe empty (not enforced).

module depth_fog_blend_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [dfb_pkg::IN_TDATA_W-1:0]      s_tdata,   // depth, red_in, green_in, blue_in
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [dfb_pkg::OUT_TDATA_W-1:0]     m_tdata,   // red_out, green_out, blue_out
  input  logic                                cfg_we,
  input  logic [dfb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dfb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int NS = dfb_pkg::NUM_STAGES;

  logic        fog_enable;
  logic [1:0]  fog_mode;
  logic [31:0] fog_end;
  logic [31:0] fog_scale;
  logic [31:0] fog_density;
  logic [2:0][15:0] fog_rgb;

  always_ff @(posedge clk) begin
    if (rst) begin
      fog_enable  <= 1'b0;
      fog_mode    <= 2'd0;
      fog_end     <= 32'd0;
      fog_scale   <= 32'd0;
      fog_density <= 32'd0;
      fog_rgb     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dfb_pkg::REG_FOG_ENABLE:  fog_enable  <= cfg_wdata[0];
        dfb_pkg::REG_FOG_MODE:    fog_mode    <= cfg_wdata[1:0];
        dfb_pkg::REG_FOG_END:     fog_end     <= cfg_wdata[31:0];
        dfb_pkg::REG_FOG_SCALE:   fog_scale   <= cfg_wdata[31:0];
        dfb_pkg::REG_FOG_DENSITY: fog_density <= cfg_wdata[31:0];
        dfb_pkg::REG_FOG_RGB:     fog_rgb     <= cfg_wdata[47:0];
        default: ;
      endcase
    end
  end

  logic               vld  [1:NS];
  logic               ld   [1:NS];
  dfb_pkg::pipe_t     pipe [1:NS];
  dfb_pkg::pipe_t     pipe_next [1:NS];

  always_comb begin
    ld[NS] = !vld[NS] || m_tready;
    for (int i = NS - 1; i >= 1; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign s_tready = ld[1];
  assign m_tvalid = vld[NS];

  // fog colour ordered blue, green, red to match col[0..2]
  logic [2:0][15:0] fog_col;
  assign fog_col[0] = fog_rgb[0];
  assign fog_col[1] = fog_rgb[1];
  assign fog_col[2] = fog_rgb[2];

  logic [30:0]                   s1_d;
  logic [47:0]                   s3_lin_q;
  logic [46:0]                   s3_x_q;
  logic [27:0]                   s5_sq_q;
  logic [6:0]                    s7_k;
  logic [15:0]                   s7_u;
  logic [dfb_pkg::POS_W-1:0]     s7_pos;
  logic [dfb_pkg::ROM_ADDR_W-1:0] s7_idx;
  logic [16:0]                   s7_a;
  logic [16:0]                   s7_b;
  logic [16:0]                   s9_v;
  logic [16:0]                   s9_fe;
  logic [16:0]                   s10_inv;
  logic [33:0]                   s11_sum [3];

  always_comb begin
    s1_d = s_tdata[31] ? 31'd0 : s_tdata[30:0];
    pipe_next[1]         = pipe[1];
    pipe_next[1].col[2]  = s_tdata[47:32];
    pipe_next[1].col[1]  = s_tdata[63:48];
    pipe_next[1].col[0]  = s_tdata[79:64];
    pipe_next[1].d       = s1_d;
    pipe_next[1].diff    = fog_end - {1'b0, s1_d};
    pipe_next[1].lin_pos = fog_end > {1'b0, s1_d};

    pipe_next[2]          = pipe[1];
    pipe_next[2].lin_prod = 64'(pipe[1].diff) * 64'(fog_scale);
    pipe_next[2].exp_prod = 63'(pipe[1].d) * 63'(fog_density);

    s3_lin_q = pipe[2].lin_prod[63:16];
    s3_x_q   = pipe[2].exp_prod[62:16];
    pipe_next[3] = pipe[2];
    if (!pipe[2].lin_pos) begin
      pipe_next[3].lin_f = 17'd0;
    end else if (s3_lin_q > 48'(dfb_pkg::ONE_Q16)) begin
      pipe_next[3].lin_f = dfb_pkg::ONE_Q16;
    end else begin
      pipe_next[3].lin_f = s3_lin_q[16:0];
    end
    pipe_next[3].x = (s3_x_q > 47'(dfb_pkg::EXP_SAT)) ? dfb_pkg::EXP_SAT : s3_x_q[21:0];

    pipe_next[4]    = pipe[3];
    pipe_next[4].sq = 44'(pipe[3].x) * 44'(pipe[3].x);

    s5_sq_q = pipe[4].sq[43:16];
    pipe_next[5] = pipe[4];
    if (!fog_mode[dfb_pkg::MODE_SQ_BIT]) begin
      pipe_next[5].e = pipe[4].x;
    end else if (s5_sq_q > 28'(dfb_pkg::EXP_SAT)) begin
      pipe_next[5].e = dfb_pkg::EXP_SAT;
    end else begin
      pipe_next[5].e = s5_sq_q[21:0];
    end

    pipe_next[6]   = pipe[5];
    pipe_next[6].y = 54'(pipe[5].e) * 54'(dfb_pkg::LOG2E_Q31);

    s7_k   = pipe[6].y[53:47];
    s7_u   = pipe[6].y[46:31];
    s7_pos = dfb_pkg::POS_W'(32'(s7_u) * dfb_pkg::EXP_TABLE_ENTRIES);
    s7_idx = dfb_pkg::ROM_ADDR_W'(s7_pos[dfb_pkg::POS_W-1:16]);
    s7_a   = dfb_pkg::EXP_ROM[s7_idx];
    s7_b   = dfb_pkg::EXP_ROM[s7_idx + 1'b1];
    pipe_next[7]      = pipe[6];
    pipe_next[7].a    = s7_a;
    pipe_next[7].dab  = s7_a - s7_b;
    pipe_next[7].r    = s7_pos[15:0];
    pipe_next[7].k    = s7_k[4:0];
    pipe_next[7].kill = s7_k > 7'd16;

    pipe_next[8]    = pipe[7];
    pipe_next[8].ip = 33'(pipe[7].dab) * 33'(pipe[7].r);

    s9_v  = pipe[8].a - pipe[8].ip[32:16];
    s9_fe = pipe[8].kill ? 17'd0 : (s9_v >> pipe[8].k);
    pipe_next[9] = pipe[8];
    if (!fog_enable) begin
      pipe_next[9].f = dfb_pkg::ONE_Q16;
    end else if (fog_mode == dfb_pkg::MODE_LINEAR) begin
      pipe_next[9].f = pipe[8].lin_f;
    end else begin
      pipe_next[9].f = s9_fe;
    end

    s10_inv = dfb_pkg::ONE_Q16 - pipe[9].f;
    pipe_next[10] = pipe[9];
    for (int c = 0; c < 3; c++) begin
      pipe_next[10].pc[c] = 33'(pipe[9].col[c]) * 33'(pipe[9].f);
      pipe_next[10].pf[c] = 33'(fog_col[c]) * 33'(s10_inv);
    end

    pipe_next[11] = pipe[10];
    for (int c = 0; c < 3; c++) begin
      s11_sum[c] = 34'(pipe[10].pc[c]) + 34'(pipe[10].pf[c]) + 34'(dfb_pkg::ROUND_HALF);
      pipe_next[11].col[c] = s11_sum[c][31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NS; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      if (ld[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= NS; i++) begin
      if (ld[i]) begin
        pipe[i] <= pipe_next[i];
      end
    end
  end

  assign m_tdata = {pipe[NS].col[0], pipe[NS].col[1], pipe[NS].col[2]};

endmodule

// ===== src/dfb_checker.sv =====
// Port-level checker for the depth fog blend core, bound to the top level.
`timescale 1ns / 1ps

module dfb_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [dfb_pkg::OUT_TDATA_W-1:0]     m_tdata
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // an output slot that is free or draining frees the whole pipe
  a_ready_when_drain: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output can move");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or dropped");

  a_out_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tready))
    else $error("result withdrawn without handshake");

endmodule

bind depth_fog_blend_core dfb_checker u_dfb_checker (.*);
